/* hw/rtl/eul2rot_pkg.sv */
// Shared constants and the fixed-point product for the Euler angle to rotation matrix block.
`timescale 1ns / 1ps

package eul2rot_pkg;

    localparam int unsigned ANGLE_WIDTH_DEF = 16;
    localparam int unsigned ENTRY_WIDTH_DEF = 16;

    localparam int unsigned Q_FRAC  = 30;
    localparam int unsigned TRIG_W  = 32;
    localparam int unsigned Z_W     = 34;
    localparam int unsigned U_W     = 31;
    localparam int unsigned X2_W    = 32;
    localparam int unsigned P_W     = 33;
    localparam int unsigned ACC_W   = 33;
    localparam int unsigned ML_W    = 18;
    localparam int unsigned MH_W    = 17;
    localparam int unsigned SUM_W   = 70;
    localparam int unsigned N_TERMS = 9;

    localparam int unsigned SINCOS_LAT = 3 * N_TERMS + 3;
    localparam int unsigned TOP_LAT    = SINCOS_LAT + 4;

    localparam logic signed [Z_W-1:0]   Q30_PI      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0]   Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [ACC_W-1:0] ACC_ONE     = 33'sd1073741824;
    localparam logic [U_W-1:0]          U_ONE       = 31'd1073741824;

    function automatic logic signed [TRIG_W-1:0] qmul(
        input logic signed [TRIG_W-1:0] a,
        input logic signed [TRIG_W-1:0] b
    );
        logic signed [TRIG_W-1:0] na;
        logic signed [TRIG_W-1:0] nb;
        logic [U_W-1:0] ma;
        logic [U_W-1:0] mb;
        logic [2*U_W-1:0] p;
        logic signed [TRIG_W-1:0] pm;
        na = -a;
        nb = -b;
        ma = a[TRIG_W-1] ? na[U_W-1:0] : a[U_W-1:0];
        mb = b[TRIG_W-1] ? nb[U_W-1:0] : b[U_W-1:0];
        p  = ma * mb;
        pm = {1'b0, p[Q_FRAC +: U_W]};
        return (a[TRIG_W-1] ^ b[TRIG_W-1]) ? -pm : pm;
    endfunction

endpackage

/* hw/rtl/eul2rot_sincos.sv */
// Pipelined sine and cosine of one angle by folded nine-term power series.
`timescale 1ns / 1ps

module eul2rot_sincos import eul2rot_pkg::*; #(
    parameter int unsigned ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);

    localparam int unsigned SHIFT = Q_FRAC + 3 - ANGLE_WIDTH;

    logic signed [Z_W-1:0] w_z;
    logic signed [Z_W-1:0] w_zf;
    logic signed [Z_W-1:0] w_zn;
    logic                  w_flip;
    logic [Z_W-1:0]        w_zmag;

    always_comb begin
        w_z    = Z_W'(i_angle) <<< SHIFT;
        w_zf   = w_z;
        w_flip = 1'b0;
        if (w_z > Q30_HALF_PI) begin
            w_zf   = w_z - Q30_PI;
            w_flip = 1'b1;
        end else if (w_z < -Q30_HALF_PI) begin
            w_zf   = w_z + Q30_PI;
            w_flip = 1'b1;
        end
        w_zn   = -w_zf;
        w_zmag = w_zf[Z_W-1] ? w_zn : w_zf;
    end

    // Bit 0 negates the sine, bit 1 negates the cosine.
    logic [U_W-1:0]    r0_u;
    logic [1:0]        r0_sg;
    logic [U_W-1:0]    r1_u;
    logic [X2_W-1:0]   r1_x2;
    logic [1:0]        r1_sg;
    logic [2*U_W-1:0]  w_sq;

    assign w_sq = r0_u * r0_u;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_u  <= w_zmag[U_W-1:0];
            r0_sg <= {w_flip, w_zf[Z_W-1] ^ w_flip};
            r1_u  <= r0_u;
            r1_x2 <= w_sq[Q_FRAC +: X2_W];
            r1_sg <= r0_sg;
        end
    end

    logic [U_W-1:0]          w_qs   [1:N_TERMS];
    logic [U_W-1:0]          w_qc   [1:N_TERMS];
    logic signed [ACC_W-1:0] w_accs [1:N_TERMS];
    logic signed [ACC_W-1:0] w_accc [1:N_TERMS];
    logic [X2_W-1:0]         w_x2   [1:N_TERMS];
    logic [1:0]              w_sg   [1:N_TERMS];

    for (genvar k = 1; k <= N_TERMS; k++) begin : g_term
        localparam int unsigned DS = (2 * k) * (2 * k + 1);
        localparam int unsigned DC = (2 * k - 1) * (2 * k);
        localparam int unsigned SS = P_W + $clog2(DS);
        localparam int unsigned SC = P_W + $clog2(DC);
        localparam logic [63:0] MS = ((64'd1 << SS) / DS) + 64'd1;
        localparam logic [63:0] MC = ((64'd1 << SC) / DC) + 64'd1;
        localparam logic [ML_W-1:0] MSL = MS[ML_W-1:0];
        localparam logic [MH_W-1:0] MSH = MS[ML_W +: MH_W];
        localparam logic [ML_W-1:0] MCL = MC[ML_W-1:0];
        localparam logic [MH_W-1:0] MCH = MC[ML_W +: MH_W];

        logic [U_W-1:0]          w_ts;
        logic [U_W-1:0]          w_tc;
        logic signed [ACC_W-1:0] w_as;
        logic signed [ACC_W-1:0] w_ac;
        logic [X2_W-1:0]         w_xi;
        logic [1:0]              w_si;
        logic [U_W+X2_W-1:0]     w_ms;
        logic [U_W+X2_W-1:0]     w_mc;
        logic [SUM_W-1:0]        w_sums;
        logic [SUM_W-1:0]        w_sumc;

        logic [P_W-1:0]          r_pas;
        logic [P_W-1:0]          r_pac;
        logic signed [ACC_W-1:0] r_acs_a;
        logic signed [ACC_W-1:0] r_acc_a;
        logic [X2_W-1:0]         r_x2_a;
        logic [1:0]              r_sg_a;
        logic [P_W+ML_W-1:0]     r_pls;
        logic [P_W+MH_W-1:0]     r_phs;
        logic [P_W+ML_W-1:0]     r_plc;
        logic [P_W+MH_W-1:0]     r_phc;
        logic signed [ACC_W-1:0] r_acs_b;
        logic signed [ACC_W-1:0] r_acc_b;
        logic [X2_W-1:0]         r_x2_b;
        logic [1:0]              r_sg_b;
        logic [U_W-1:0]          r_qs;
        logic [U_W-1:0]          r_qc;
        logic signed [ACC_W-1:0] r_acs_c;
        logic signed [ACC_W-1:0] r_acc_c;
        logic [X2_W-1:0]         r_x2_c;
        logic [1:0]              r_sg_c;

        if (k == 1) begin : g_first
            assign w_ts = r1_u;
            assign w_as = {2'b00, r1_u};
            assign w_tc = U_ONE;
            assign w_ac = ACC_ONE;
            assign w_xi = r1_x2;
            assign w_si = r1_sg;
        end else begin : g_next
            assign w_ts = w_qs[k-1];
            assign w_tc = w_qc[k-1];
            assign w_as = ((k - 1) % 2 == 1) ? w_accs[k-1] - {2'b00, w_qs[k-1]}
                                             : w_accs[k-1] + {2'b00, w_qs[k-1]};
            assign w_ac = ((k - 1) % 2 == 1) ? w_accc[k-1] - {2'b00, w_qc[k-1]}
                                             : w_accc[k-1] + {2'b00, w_qc[k-1]};
            assign w_xi = w_x2[k-1];
            assign w_si = w_sg[k-1];
        end

        assign w_ms   = w_ts * w_xi;
        assign w_mc   = w_tc * w_xi;
        assign w_sums = SUM_W'(r_pls) + (SUM_W'(r_phs) << ML_W);
        assign w_sumc = SUM_W'(r_plc) + (SUM_W'(r_phc) << ML_W);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pas   <= w_ms[Q_FRAC +: P_W];
                r_pac   <= w_mc[Q_FRAC +: P_W];
                r_acs_a <= w_as;
                r_acc_a <= w_ac;
                r_x2_a  <= w_xi;
                r_sg_a  <= w_si;
                r_pls   <= r_pas * MSL;
                r_phs   <= r_pas * MSH;
                r_plc   <= r_pac * MCL;
                r_phc   <= r_pac * MCH;
                r_acs_b <= r_acs_a;
                r_acc_b <= r_acc_a;
                r_x2_b  <= r_x2_a;
                r_sg_b  <= r_sg_a;
                r_qs    <= w_sums[SS +: U_W];
                r_qc    <= w_sumc[SC +: U_W];
                r_acs_c <= r_acs_b;
                r_acc_c <= r_acc_b;
                r_x2_c  <= r_x2_b;
                r_sg_c  <= r_sg_b;
            end
        end

        assign w_qs[k]   = r_qs;
        assign w_qc[k]   = r_qc;
        assign w_accs[k] = r_acs_c;
        assign w_accc[k] = r_acc_c;
        assign w_x2[k]   = r_x2_c;
        assign w_sg[k]   = r_sg_c;
    end

    logic signed [ACC_W-1:0] w_fs;
    logic signed [ACC_W-1:0] w_fc;
    logic signed [ACC_W-1:0] w_ss;
    logic signed [ACC_W-1:0] w_cc;
    logic signed [ACC_W-1:0] w_sk;
    logic signed [ACC_W-1:0] w_ck;

    always_comb begin
        w_fs = w_accs[N_TERMS] - {2'b00, w_qs[N_TERMS]};
        w_fc = w_accc[N_TERMS] - {2'b00, w_qc[N_TERMS]};
        w_ss = w_sg[N_TERMS][0] ? -w_fs : w_fs;
        w_cc = w_sg[N_TERMS][1] ? -w_fc : w_fc;
        w_sk = w_ss;
        if (w_ss > ACC_ONE) begin
            w_sk = ACC_ONE;
        end else if (w_ss < -ACC_ONE) begin
            w_sk = -ACC_ONE;
        end
        w_ck = w_cc;
        if (w_cc > ACC_ONE) begin
            w_ck = ACC_ONE;
        end else if (w_cc < -ACC_ONE) begin
            w_ck = -ACC_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= w_sk[TRIG_W-1:0];
            o_cos <= w_ck[TRIG_W-1:0];
        end
    end

endmodule

/* hw/rtl/xyz_euler_to_rotation_matrix_top.sv */
// Top level: XYZ Euler angles in, the nine rotation matrix entries out.
`timescale 1ns / 1ps

// Takes one request of roll, pitch and yaw (signed, ANGLE_WIDTH-3 fraction bits) per clock
// and returns the nine entries of the XYZ rotation matrix (signed, ENTRY_WIDTH-2 fraction
// bits, saturated to plus or minus one). Sine and cosine come from a
// nine-term power series after folding the angle by pi, each term taking three stages
// (square product, reciprocal product, quotient), followed by four stages of products,
// sums and rounding. The whole pipeline holds while a result waits at the output, so the
// sustained rate is one request per cycle when the output side takes every cycle.
module xyz_euler_to_rotation_matrix_top import eul2rot_pkg::*; #(
    parameter int unsigned ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int unsigned ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // roll_angle, pitch_angle, yaw_angle
    input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic [((9*ENTRY_WIDTH+7)/8)*8-1:0] o_m_tdata
);

    localparam int unsigned OUT_W = ((9 * ENTRY_WIDTH + 7) / 8) * 8;
    localparam int unsigned SH    = Q_FRAC + 2 - ENTRY_WIDTH;
    localparam logic [ACC_W:0] LIM = (ACC_W + 1)'(1) << (ENTRY_WIDTH - 2);
    localparam logic signed [ENTRY_WIDTH-1:0] ENT_LIM = ENTRY_WIDTH'(1) << (ENTRY_WIDTH - 2);

    logic                 w_en;
    logic [TOP_LAT-1:0]   r_vld;

    assign w_en       = !r_vld[TOP_LAT-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[TOP_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOP_LAT-2:0], i_s_tvalid};
        end
    end

    logic signed [TRIG_W-1:0] w_sr, w_cr, w_sp, w_cp, w_sy, w_cy;

    eul2rot_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_s_tdata[ANGLE_WIDTH-1:0]),
        .o_sin  (w_sr),
        .o_cos  (w_cr)
    );

    eul2rot_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_s_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]),
        .o_sin  (w_sp),
        .o_cos  (w_cp)
    );

    eul2rot_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_s_tdata[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]),
        .o_sin  (w_sy),
        .o_cos  (w_cy)
    );

    logic signed [TRIG_W-1:0] r1_sr, r1_cr, r1_sp, r1_cp, r1_sy, r1_cy;
    logic signed [TRIG_W-1:0] r1_cysp, r1_spsy;
    logic signed [TRIG_W-1:0] r2_p [0:11];
    logic signed [TRIG_W-1:0] r2_sp;
    logic signed [ACC_W-1:0]  r3_e [0:8];
    logic signed [ENTRY_WIDTH-1:0] r4_m [0:8];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sr   <= w_sr;
            r1_cr   <= w_cr;
            r1_sp   <= w_sp;
            r1_cp   <= w_cp;
            r1_sy   <= w_sy;
            r1_cy   <= w_cy;
            r1_cysp <= qmul(w_cy, w_sp);
            r1_spsy <= qmul(w_sp, w_sy);

            r2_p[0]  <= qmul(r1_cp, r1_cy);
            r2_p[1]  <= qmul(r1_cp, r1_sy);
            r2_p[2]  <= qmul(r1_cr, r1_sy);
            r2_p[3]  <= qmul(r1_sr, r1_cysp);
            r2_p[4]  <= qmul(r1_cr, r1_cy);
            r2_p[5]  <= qmul(r1_sr, r1_spsy);
            r2_p[6]  <= qmul(r1_cp, r1_sr);
            r2_p[7]  <= qmul(r1_sr, r1_sy);
            r2_p[8]  <= qmul(r1_cr, r1_cysp);
            r2_p[9]  <= qmul(r1_cr, r1_spsy);
            r2_p[10] <= qmul(r1_cy, r1_sr);
            r2_p[11] <= qmul(r1_cr, r1_cp);
            r2_sp    <= r1_sp;

            r3_e[0] <= ACC_W'(r2_p[0]);
            r3_e[1] <= -ACC_W'(r2_p[1]);
            r3_e[2] <= ACC_W'(r2_sp);
            r3_e[3] <= ACC_W'(r2_p[2]) + ACC_W'(r2_p[3]);
            r3_e[4] <= ACC_W'(r2_p[4]) - ACC_W'(r2_p[5]);
            r3_e[5] <= -ACC_W'(r2_p[6]);
            r3_e[6] <= ACC_W'(r2_p[7]) - ACC_W'(r2_p[8]);
            r3_e[7] <= ACC_W'(r2_p[9]) + ACC_W'(r2_p[10]);
            r3_e[8] <= ACC_W'(r2_p[11]);
        end
    end

    logic [8:0] w_ok;

    for (genvar j = 0; j < 9; j++) begin : g_entry
        logic signed [ACC_W-1:0] w_ne;
        logic [ACC_W-1:0]        w_mag;
        logic [ACC_W:0]          w_rnd;
        logic [ACC_W:0]          w_sat;
        logic [ENTRY_WIDTH-1:0]  w_pos;
        logic [ENTRY_WIDTH-1:0]  w_neg;

        assign w_ne  = -r3_e[j];
        assign w_mag = r3_e[j][ACC_W-1] ? w_ne : r3_e[j];

        if (SH > 0) begin : g_round
            assign w_rnd = ({1'b0, w_mag} + ((ACC_W + 1)'(1) << (SH - 1))) >> SH;
        end else begin : g_exact
            assign w_rnd = {1'b0, w_mag};
        end

        assign w_sat = (w_rnd > LIM) ? LIM : w_rnd;
        assign w_pos = w_sat[ENTRY_WIDTH-1:0];
        assign w_neg = -w_pos;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r4_m[j] <= r3_e[j][ACC_W-1] ? w_neg : w_pos;
            end
        end

        assign o_m_tdata[j*ENTRY_WIDTH +: ENTRY_WIDTH] = r4_m[j];
        assign w_ok[j] = (r4_m[j] <= ENT_LIM) && (r4_m[j] >= -ENT_LIM);
    end

    if (OUT_W > 9 * ENTRY_WIDTH) begin : g_pad
        assign o_m_tdata[OUT_W-1:9*ENTRY_WIDTH] = '0;
    end

    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_ok == 9'h1ff))
        else $error("matrix entry beyond plus or minus one");

    a_enter : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted request not tracked in the pipeline");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

    a_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule
